// File: sv/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bpfa assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("bpfa forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// File: sv/bpfa_pkg.sv
// Types and fixed constants of the bitmap page frame allocator.
// No dependencies; imported by every allocator module.
`default_nettype none

package bpfa_pkg;

    localparam int ADDR_W      = 32;
    localparam int WORD_BITS   = 32;
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int FRAME_BYTES = 4096;
    localparam int FRAME_SHIFT = $clog2(FRAME_BYTES);
    // frame index / frame count, wide enough for ceil(2^32 / FRAME_BYTES)
    localparam int IDX_W       = ADDR_W - FRAME_SHIFT + 1;
    localparam int FREE_W      = 21;

    typedef logic [WORD_BITS-1:0] t_word;
    localparam t_word FULL_WORD = '1;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_RESERVE = 2'd2,
        CMD_RELEASE = 2'd3
    } t_cmd_e;

    typedef struct packed {
        t_cmd_e            command;
        logic [ADDR_W-1:0] byte_address;
        logic [ADDR_W-1:0] byte_size;
    } t_cmd_in;

    typedef struct packed {
        logic [ADDR_W-1:0] frame_address;
        logic              status;
        logic [FREE_W-1:0] free_frames;
    } t_result;

    // clipped frame range of a free, reserve or release command
    typedef struct packed {
        logic             set_used;
        logic [IDX_W-1:0] base;
        logic [IDX_W-1:0] count;
    } t_range;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_RANGE,
        ST_RMW,
        ST_SCAN,
        ST_DONE
    } t_state_e;

endpackage

`default_nettype wire

// File: sv/bpfa_bitmap_ram.sv
// Bitmap word store: one write port, one read port, registered read data.
// Depends on bpfa_pkg for the word type.
`default_nettype none

module bpfa_bitmap_ram import bpfa_pkg::*; #(
    parameter int DEPTH = 32768,
    parameter int AW    = 15
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_word         i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_word              o_rd_data
);

    t_word r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: sv/bpfa_first_zero.sv
// Finds the lowest clear bit of a bitmap word (binary search, log2 steps).
// Depends on bpfa_pkg.
`default_nettype none

module bpfa_first_zero import bpfa_pkg::*; (
    input  wire t_word        i_word,
    output logic              o_found,
    output logic [BIT_W-1:0]  o_idx
);

    always_comb begin
        t_word v;
        v       = ~i_word;
        o_found = |v;
        o_idx   = '0;
        for (int k = BIT_W - 1; k >= 0; k--) begin
            if ((v & ((t_word'(1) << (1 << k)) - t_word'(1))) == '0) begin
                o_idx[k] = 1'b1;
                v        = v >> (1 << k);
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/bpfa_range_decode.sv
// Turns a free / reserve / release command into a clipped frame range.
// Depends on bpfa_pkg.
`default_nettype none

module bpfa_range_decode import bpfa_pkg::*; #(
    parameter int NUM_FRAMES = 1048576
) (
    input  wire t_cmd_in i_cmd,
    output t_range       o_range
);

    localparam logic [IDX_W-1:0] NUM_F = IDX_W'(NUM_FRAMES);

    always_comb begin
        logic [IDX_W-1:0] base;
        logic [IDX_W-1:0] cnt;
        logic [IDX_W-1:0] room;
        logic             set_used;
        base     = '0;
        cnt      = '0;
        set_used = 1'b0;
        unique case (i_cmd.command)
            CMD_FREE: begin
                base = IDX_W'(i_cmd.byte_address[ADDR_W-1:FRAME_SHIFT]);
                cnt  = IDX_W'(1);
            end
            CMD_RESERVE: begin
                base     = IDX_W'(i_cmd.byte_address[ADDR_W-1:FRAME_SHIFT]);
                cnt      = IDX_W'(i_cmd.byte_size[ADDR_W-1:FRAME_SHIFT])
                         + IDX_W'(i_cmd.byte_size[FRAME_SHIFT-1:0] != '0);
                set_used = 1'b1;
            end
            CMD_RELEASE: begin
                // first whole frame at or above the address
                base = IDX_W'(i_cmd.byte_address[ADDR_W-1:FRAME_SHIFT])
                     + IDX_W'(i_cmd.byte_address[FRAME_SHIFT-1:0] != '0);
                cnt  = IDX_W'(i_cmd.byte_size[ADDR_W-1:FRAME_SHIFT]);
            end
            CMD_ALLOC: begin
                cnt = '0;
            end
        endcase
        room             = NUM_F - base;
        o_range.set_used = set_used;
        o_range.base     = base;
        if (base >= NUM_F) begin
            o_range.count = '0;
        end else if (cnt > room) begin
            o_range.count = room;
        end else begin
            o_range.count = cnt;
        end
    end

endmodule

`default_nettype wire

// File: sv/bitmap_page_frame_allocator_core.sv
// Bitmap page frame allocator: command sequencer, used-frame count, search hint.
// Depends on bpfa_pkg, bpfa_bitmap_ram, bpfa_first_zero, bpfa_range_decode.
//
// Usage
//   Command channel: i_cmd is taken at a rising edge with start high and busy low.
//   Result channel: o_result is valid for the single cycle o_done is high; the
//   receiver has no way to stall it, one result per command.
//   Reset: after i_rst_n rises the bitmap RAM is swept to all-used, one word per
//   cycle, MAP_WORDS cycles (32768 at the default size); busy stays high meanwhile.
//   Command flow, from the accepting edge to the o_done cycle:
//     alloc   decode, then a scan of the bitmap words from the search hint up to
//             the one with a free frame, or to the map end when none is free
//             (no scan when the count shows no free frame or the hint is exhausted);
//     reserve, release, free  decode, then one write per fully covered word
//             and a read-modify-write per partly covered word;
//             no map access when the clipped range is empty.
//   The bitmap RAM's single read and write port sets the pace: one word a cycle,
//   but a partly covered word is first read and then written back.
//   The next command is taken the cycle after o_done.
`default_nettype none
`include "assert_macros.svh"

module bitmap_page_frame_allocator_core import bpfa_pkg::*; #(
    parameter int NUM_FRAMES = 1048576
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire t_cmd_in i_cmd,
    output logic         o_done,
    output t_result      o_result
);

    localparam int MAP_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int PW        = $clog2(MAP_WORDS + 1);

    localparam logic [IDX_W-1:0] NUM_F     = IDX_W'(NUM_FRAMES);
    localparam logic [IDX_W-1:0] WORD_F    = IDX_W'(WORD_BITS);
    localparam logic [PW-1:0]    HINT_NONE = PW'(MAP_WORDS);
    localparam logic [AW-1:0]    LAST_WORD = AW'(MAP_WORDS - 1);
    localparam logic [BIT_W-1:0] TOP_BIT   = BIT_W'(WORD_BITS - 1);

    t_state_e          r_state, n_state;
    t_cmd_in           r_cmd, n_cmd;
    logic [IDX_W-1:0]  r_used, n_used;
    logic [PW-1:0]     r_hint, n_hint;
    logic [IDX_W-1:0]  r_cur, n_cur;
    logic [IDX_W-1:0]  r_end, n_end;
    logic              r_set, n_set;
    logic [AW-1:0]     r_word, n_word;
    t_word             r_mask, n_mask;
    logic [PW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [AW-1:0]     r_chk_ptr, n_chk_ptr;
    logic              r_chk_vld, n_chk_vld;
    logic [AW-1:0]     r_init_ptr, n_init_ptr;
    logic [ADDR_W-1:0] r_faddr, n_faddr;
    logic              r_status, n_status;

    logic              mem_wr_en;
    logic [AW-1:0]     mem_wr_addr;
    t_word             mem_wr_data;
    logic              mem_rd_en;
    logic [AW-1:0]     mem_rd_addr;
    t_word             mem_rd_data;

    logic              zf_found;
    logic [BIT_W-1:0]  zf_idx;
    t_range            dec;

    // range walk helpers
    logic [AW-1:0]     cur_word;
    logic [BIT_W-1:0]  cur_bit;
    logic [IDX_W-1:0]  last_idx;
    logic              is_last;
    logic [BIT_W-1:0]  hi_bit;
    logic              full_cover;
    t_word             part_mask;
    logic [IDX_W-1:0]  part_next;
    logic              alloc_none;

    bpfa_bitmap_ram #(
        .DEPTH (MAP_WORDS),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    bpfa_first_zero u_zero (
        .i_word  (mem_rd_data),
        .o_found (zf_found),
        .o_idx   (zf_idx)
    );

    bpfa_range_decode #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_decode (
        .i_cmd   (r_cmd),
        .o_range (dec)
    );

    always_comb begin
        cur_word   = AW'(r_cur >> BIT_W);
        cur_bit    = r_cur[BIT_W-1:0];
        last_idx   = r_end - IDX_W'(1);
        is_last    = (last_idx >> BIT_W) == (r_cur >> BIT_W);
        hi_bit     = is_last ? last_idx[BIT_W-1:0] : TOP_BIT;
        full_cover = (cur_bit == '0) && ((r_end - r_cur) >= WORD_F);
        part_mask  = (FULL_WORD << cur_bit) & (FULL_WORD >> (TOP_BIT - hi_bit));
        part_next  = is_last ? r_end : (((r_cur >> BIT_W) + IDX_W'(1)) << BIT_W);
        alloc_none = (r_used >= NUM_F) || (r_hint == HINT_NONE);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (r_init_ptr == LAST_WORD) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (r_cmd.command == CMD_ALLOC) begin
                    n_state = alloc_none ? ST_DONE : ST_SCAN;
                end else begin
                    n_state = (dec.count == '0) ? ST_DONE : ST_RANGE;
                end
            end
            ST_RANGE: begin
                if (!full_cover) begin
                    n_state = ST_RMW;
                end else if (r_cur + WORD_F == r_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_RMW: begin
                n_state = (r_cur == r_end) ? ST_DONE : ST_RANGE;
            end
            ST_SCAN: begin
                if (r_chk_vld && zf_found) begin
                    n_state = ST_DONE;
                end else if (!r_chk_vld && r_rd_ptr == HINT_NONE) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath and RAM control
    always_comb begin
        logic [IDX_W:0] sum;
        n_cmd       = r_cmd;
        n_used      = r_used;
        n_hint      = r_hint;
        n_cur       = r_cur;
        n_end       = r_end;
        n_set       = r_set;
        n_word      = r_word;
        n_mask      = r_mask;
        n_rd_ptr    = r_rd_ptr;
        n_chk_ptr   = r_chk_ptr;
        n_chk_vld   = r_chk_vld;
        n_init_ptr  = r_init_ptr;
        n_faddr     = r_faddr;
        n_status    = r_status;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_word;
        mem_wr_data = FULL_WORD;
        mem_rd_en   = 1'b0;
        mem_rd_addr = cur_word;
        sum         = {1'b0, r_used} + {1'b0, dec.count};
        unique case (r_state)
            ST_INIT: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_init_ptr;
                mem_wr_data = FULL_WORD;
                n_init_ptr  = r_init_ptr + AW'(1);
            end
            ST_IDLE: begin
                if (start) begin
                    n_cmd = i_cmd;
                end
                n_faddr  = '0;
                n_status = 1'b0;
            end
            ST_DECODE: begin
                if (r_cmd.command == CMD_ALLOC) begin
                    n_rd_ptr  = r_hint;
                    n_chk_vld = 1'b0;
                    n_status  = alloc_none;
                end else begin
                    n_cur = dec.base;
                    n_end = dec.base + dec.count;
                    n_set = dec.set_used;
                    if (dec.set_used) begin
                        n_used = (sum > {1'b0, NUM_F}) ? NUM_F : sum[IDX_W-1:0];
                    end else begin
                        n_used = (r_used >= dec.count) ? (r_used - dec.count) : '0;
                        // cleared frames may sit below the hint
                        if (dec.count != '0 && IDX_W'(r_hint) > (dec.base >> BIT_W)) begin
                            n_hint = PW'(dec.base >> BIT_W);
                        end
                    end
                end
            end
            ST_RANGE: begin
                if (full_cover) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = cur_word;
                    mem_wr_data = r_set ? FULL_WORD : '0;
                    n_cur       = r_cur + WORD_F;
                end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = cur_word;
                    n_word      = cur_word;
                    n_mask      = part_mask;
                    n_cur       = part_next;
                end
            end
            ST_RMW: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_word;
                mem_wr_data = r_set ? (mem_rd_data | r_mask) : (mem_rd_data & ~r_mask);
            end
            ST_SCAN: begin
                // reads stream ahead; each word is checked the cycle after its read
                if (r_rd_ptr != HINT_NONE) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = AW'(r_rd_ptr);
                    n_rd_ptr    = r_rd_ptr + PW'(1);
                    n_chk_ptr   = AW'(r_rd_ptr);
                    n_chk_vld   = 1'b1;
                end else begin
                    n_chk_vld   = 1'b0;
                end
                if (r_chk_vld && zf_found) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = r_chk_ptr;
                    mem_wr_data = mem_rd_data | (t_word'(1) << zf_idx);
                    n_used      = (r_used >= NUM_F) ? NUM_F : (r_used + IDX_W'(1));
                    n_hint      = PW'(r_chk_ptr);
                    n_faddr     = ADDR_W'({r_chk_ptr, zf_idx, {FRAME_SHIFT{1'b0}}});
                    n_chk_vld   = 1'b0;
                end else if (!r_chk_vld && r_rd_ptr == HINT_NONE) begin
                    n_status = 1'b1;
                    n_hint   = HINT_NONE;
                end
            end
            ST_DONE: begin
                n_chk_vld = 1'b0;
            end
            default: begin
                n_chk_vld = 1'b0;
            end
        endcase
    end

    // outputs
    always_comb begin
        busy                   = (r_state != ST_IDLE);
        o_done                 = (r_state == ST_DONE);
        o_result.frame_address = r_faddr;
        o_result.status        = r_status;
        o_result.free_frames   = FREE_W'(NUM_F - r_used);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_INIT;
            r_init_ptr <= '0;
            r_used     <= NUM_F;
            r_hint     <= HINT_NONE;
            r_chk_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_init_ptr <= n_init_ptr;
            r_used     <= n_used;
            r_hint     <= n_hint;
            r_chk_vld  <= n_chk_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_cur     <= n_cur;
        r_end     <= n_end;
        r_set     <= n_set;
        r_word    <= n_word;
        r_mask    <= n_mask;
        r_rd_ptr  <= n_rd_ptr;
        r_chk_ptr <= n_chk_ptr;
        r_faddr   <= n_faddr;
        r_status  <= n_status;
    end

    `ASSERT_CLK(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy)
    `ASSERT_CLK(a_done_pulse, i_clk, i_rst_n, o_done |=> !o_done)
    `ASSERT_NEVER(a_used_range, i_clk, i_rst_n, r_used > NUM_F)
    `ASSERT_CLK(a_oom_addr, i_clk, i_rst_n, (o_done && o_result.status) |-> (o_result.frame_address == '0))
    `ASSERT_CLK(a_rmw_order, i_clk, i_rst_n, (r_state == ST_RMW) |-> ($past(r_state) == ST_RANGE))
    `ASSERT_NEVER(a_wr_addr, i_clk, i_rst_n, mem_wr_en && (mem_wr_addr > LAST_WORD))

endmodule

`default_nettype wire

// File: verif/bitmap_page_frame_allocator_core_tb.sv
// Self-checking testbench for bitmap_page_frame_allocator_core: directed and random commands,
// with results checked against a bit-level model of the frame map and used-frame count.
// Depends on bpfa_pkg and the allocator RTL only.
module bitmap_page_frame_allocator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bpfa_pkg::*;

    localparam int NUM_FRAMES   = 1048576;
    localparam int MAP_WORDS    = NUM_FRAMES / WORD_BITS;
    localparam int RANDOM_ITEMS = 1850;
    // random traffic lives mostly in the first LOW_FRAMES frames
    localparam int LOW_FRAMES   = 2048;
    localparam int LOW_BYTES    = LOW_FRAMES * FRAME_BYTES;
    // anything walking more map words than this counts as a slow command
    localparam int FAR_WORDS    = 256;
    localparam int FAR_FRAMES   = FAR_WORDS * WORD_BITS;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_cmd_in cmd_in  = '0;
    logic    busy;
    logic    o_done;
    t_result o_result;

    // model state: 1 = frame in use
    t_word       frame_map [MAP_WORDS];
    int unsigned used_count;
    int unsigned scan_from;   // no clear bit in any word below this one

    t_result pending_results [$];
    int      errors = 0;
    int      results_checked = 0;
    int      commands_sent [4];
    int      allocs_granted = 0;
    int      allocs_refused = 0;
    int      big_ranges_left = 12;
    int      long_scans_left = 4;

    bitmap_page_frame_allocator_core #(.NUM_FRAMES(NUM_FRAMES)) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (cmd_in),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #200_000_000;
        $display("bitmap_page_frame_allocator_core verification failed");
        $finish;
    end

    // ---------------------------------------------------------------- model

    function automatic void clear_frame_map();
        for (int w = 0; w < MAP_WORDS; w++) frame_map[w] = FULL_WORD;
        used_count = NUM_FRAMES;
        scan_from  = MAP_WORDS;
    endfunction

    function automatic int unsigned lowest_free_word();
        int unsigned w;
        w = scan_from;
        while (w < MAP_WORDS && frame_map[w] == FULL_WORD) w++;
        scan_from = w;
        return w;
    endfunction

    function automatic void add_used(longint unsigned n);
        longint unsigned u;
        u = used_count + n;
        used_count = (u > NUM_FRAMES) ? NUM_FRAMES : u;
    endfunction

    function automatic void sub_used(longint unsigned n);
        used_count = (used_count >= n) ? used_count - n : 0;
    endfunction

    // first frame and clipped frame count of a reserve or release
    function automatic void range_of(input t_cmd_in c, output longint unsigned base,
                                     output longint unsigned n);
        longint unsigned a, s;
        a = c.byte_address;
        s = c.byte_size;
        if (c.command == CMD_RESERVE) begin
            base = a >> FRAME_SHIFT;
            n    = (s + FRAME_BYTES - 1) >> FRAME_SHIFT;
        end else begin
            base = (a + FRAME_BYTES - 1) >> FRAME_SHIFT;
            n    = s >> FRAME_SHIFT;
        end
        if (base >= NUM_FRAMES) n = 0;
        else if (n > NUM_FRAMES - base) n = NUM_FRAMES - base;
    endfunction

    function automatic void mark_frames(longint unsigned base, longint unsigned n, bit used);
        longint unsigned f, stop;
        f    = base;
        stop = base + n;
        while (f < stop) begin
            if (f % WORD_BITS == 0 && stop - f >= WORD_BITS) begin
                frame_map[f / WORD_BITS] = used ? FULL_WORD : '0;
                f += WORD_BITS;
            end else begin
                frame_map[f / WORD_BITS][f % WORD_BITS] = used;
                f++;
            end
        end
        if (!used && n != 0 && base / WORD_BITS < scan_from) scan_from = base / WORD_BITS;
    endfunction

    function automatic t_result predict_result(t_cmd_in c);
        t_result         r;
        longint unsigned base, n, f;
        int unsigned     w;
        int              b;
        r = '0;
        case (c.command)
            CMD_ALLOC: begin
                w = (used_count >= NUM_FRAMES) ? MAP_WORDS : lowest_free_word();
                if (w >= MAP_WORDS) begin
                    r.status = 1'b1;
                end else begin
                    b = 0;
                    while (frame_map[w][b] == 1'b1) b++;
                    frame_map[w][b] = 1'b1;
                    add_used(1);
                    f = longint'(w) * WORD_BITS + b;
                    r.frame_address = ADDR_W'(f << FRAME_SHIFT);
                end
            end
            CMD_FREE: begin
                f = c.byte_address >> FRAME_SHIFT;
                if (f < NUM_FRAMES) begin
                    frame_map[f / WORD_BITS][f % WORD_BITS] = 1'b0;
                    if (f / WORD_BITS < scan_from) scan_from = f / WORD_BITS;
                    sub_used(1);
                end
            end
            default: begin
                range_of(c, base, n);
                mark_frames(base, n, c.command == CMD_RESERVE);
                if (c.command == CMD_RESERVE) add_used(n);
                else sub_used(n);
            end
        endcase
        r.free_frames = FREE_W'(NUM_FRAMES - used_count);
        return r;
    endfunction

    // ------------------------------------------------------- drive and check

    task automatic flag_error(input string what);
        errors++;
        if (errors <= 10) $display("%0t ns: %s", $time, what);
    endtask

    task automatic send_command(input t_cmd_in c);
        t_result want;
        @(negedge i_clk);
        start  <= 1'b1;
        cmd_in <= c;
        do @(posedge i_clk); while (busy !== 1'b0);
        want = predict_result(c);
        pending_results.push_back(want);
        commands_sent[c.command]++;
        if (c.command == CMD_ALLOC) begin
            if (want.status) allocs_refused++;
            else allocs_granted++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && $isunknown(o_done)) begin
            flag_error("done strobe unknown");
        end else if (i_rst_n && o_done) begin
            results_checked++;
            if (pending_results.size() == 0) begin
                flag_error($sformatf("result beat with nothing expected: %p", o_result));
            end else begin
                want = pending_results.pop_front();
                if (o_result.frame_address !== want.frame_address ||
                    o_result.status !== want.status ||
                    o_result.free_frames !== want.free_frames)
                    flag_error($sformatf({"result %0d: expected addr %h status %0d free %0d,",
                        " got addr %h status %0d free %0d"}, results_checked,
                        want.frame_address, want.status, want.free_frames,
                        o_result.frame_address, o_result.status, o_result.free_frames));
            end
        end
    end

    // ------------------------------------------------------------- stimulus

    function automatic t_cmd_in make_item(t_cmd_e op, logic [31:0] addr, logic [31:0] size);
        t_cmd_in c;
        c.command      = op;
        c.byte_address = addr;
        c.byte_size    = size;
        return c;
    endfunction

    function automatic logic [31:0] pick_address();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(0, LOW_BYTES - 1);
        if (r < 90) return 32'hFFFF_FFFF - $urandom_range(0, 256 * FRAME_BYTES);
        return $urandom();
    endfunction

    function automatic logic [31:0] pick_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(0, 16 * FRAME_BYTES);
        if (r < 85) return $urandom_range(0, 256 * FRAME_BYTES);
        if (r < 95) return FRAME_BYTES * $urandom_range(0, 8);
        return $urandom();
    endfunction

    // Slow commands (long map walks) are rationed; past the ration an alloc
    // that would walk far becomes a small release in the busy region.
    function automatic t_cmd_in make_random_command();
        t_cmd_in         c;
        int unsigned     pick, w;
        longint unsigned base, n;
        pick = $urandom_range(0, 99);
        c = make_item(CMD_RELEASE, pick_address(), pick_size());
        if (pick < 35) c.command = CMD_ALLOC;
        else if (pick < 58) c.command = CMD_FREE;
        else if (pick < 73) c.command = CMD_RESERVE;
        if (c.command == CMD_ALLOC) begin
            w = lowest_free_word();
            if (used_count < NUM_FRAMES && w > FAR_WORDS) begin
                if (long_scans_left > 0) long_scans_left--;
                else c = make_item(CMD_RELEASE, $urandom_range(0, LOW_BYTES - 1),
                                   $urandom_range(0, 32 * FRAME_BYTES));
            end
        end else if (c.command != CMD_FREE) begin
            range_of(c, base, n);
            if (n > FAR_FRAMES) begin
                if (big_ranges_left > 0) big_ranges_left--;
                else c.byte_size = c.byte_size & 32'h000F_FFFF;
            end
        end
        return c;
    endfunction

    // everything used after the sweep; small ranges, rounding and a stale count
    task automatic test_boot_state();
        send_command(make_item(CMD_ALLOC,   32'h0000_0000, 32'h0000_0000));
        send_command(make_item(CMD_RELEASE, 32'hFFFF_F001, 32'hFFFF_FFFF));
        send_command(make_item(CMD_RESERVE, 32'h0000_0000, 32'h0000_0000));
        send_command(make_item(CMD_RELEASE, 32'h0000_1001, 32'h0000_3FFF));
        send_command(make_item(CMD_ALLOC,   32'h0000_0000, 32'h0000_0000));
        // frame 3 is already free: the count drifts below the map
        send_command(make_item(CMD_FREE,    32'h0000_3FFF, 32'h0000_0000));
        send_command(make_item(CMD_ALLOC,   32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_command(make_item(CMD_ALLOC,   32'h0000_0000, 32'h0000_0000));
        // count still shows one free frame, the scan finds none
        send_command(make_item(CMD_ALLOC,   32'h0000_0000, 32'h0000_0000));
        send_command(make_item(CMD_RESERVE, 32'h0000_5FFF, 32'h0000_0001));
    endtask

    task automatic test_count_limits();
        send_command(make_item(CMD_RESERVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_command(make_item(CMD_RELEASE, 32'h0000_0000, 32'hFFFF_FFFF));
        send_command(make_item(CMD_RELEASE, 32'h0000_0000, 32'hFFFF_FFFF));
        send_command(make_item(CMD_ALLOC,   32'h0000_0000, 32'h0000_0000));
        send_command(make_item(CMD_FREE,    32'hFFFF_FFFF, 32'h0000_0000));
        send_command(make_item(CMD_FREE,    32'h0000_0000, 32'hFFFF_FFFF));
        send_command(make_item(CMD_FREE,    32'h0000_0000, 32'h0000_0000));
        send_command(make_item(CMD_RESERVE, 32'h0000_0FFF, 32'h0000_1001));
        send_command(make_item(CMD_RESERVE, 32'h0000_0000, 32'hFFFF_FFFF));
        send_command(make_item(CMD_ALLOC,   32'h0000_0000, 32'h0000_0000));
    endtask

    // only the last two frames free: alloc has to walk to the end of the map
    task automatic test_map_end();
        send_command(make_item(CMD_RELEASE, 32'hFFFF_E000, 32'h0000_2000));
        send_command(make_item(CMD_ALLOC,   32'h0000_0000, 32'h0000_0000));
        send_command(make_item(CMD_ALLOC,   32'h0000_0000, 32'h0000_0000));
        send_command(make_item(CMD_RELEASE, 32'h0000_0000, LOW_BYTES));
    endtask

    task automatic test_random_traffic(input int n_items);
        int burst_left;
        int gap;
        burst_left = 0;
        for (int i = 0; i < n_items; i++) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                  : $urandom_range(1, 12);
                repeat (gap) @(negedge i_clk) start <= 1'b0;
                burst_left = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 16);
            end
            send_command(make_random_command());
            burst_left--;
        end
    endtask

    initial begin
        clear_frame_map();
        foreach (commands_sent[k]) commands_sent[k] = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_boot_state();
        test_count_limits();
        test_map_end();
        test_random_traffic(RANDOM_ITEMS);
        @(negedge i_clk) start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        $display("Sent %0d alloc, %0d free, %0d reserve, %0d release; %0d results checked.",
                 commands_sent[CMD_ALLOC], commands_sent[CMD_FREE],
                 commands_sent[CMD_RESERVE], commands_sent[CMD_RELEASE], results_checked);
        $display("Allocs granted %0d, refused %0d; %0d errors, %0d results outstanding.",
                 allocs_granted, allocs_refused, errors, pending_results.size());
        if (errors == 0 && pending_results.size() == 0) begin
            $display("bitmap_page_frame_allocator_core verification clean");
        end else begin
            $display("bitmap_page_frame_allocator_core verification failed");
        end
        $finish;
    end

endmodule
